// File: rtl/sobb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobb_pkg: shared types and constants of the segment/box slab pipeline
// Field widths, internal arithmetic widths and stage latencies.
// ----------------------------------------------------------------------------
package sobb_pkg;

  localparam int unsigned COORD_BITS     = 20;
  localparam int unsigned AXIS_FRAC_BITS = 14;
  localparam int unsigned AXIS_BITS      = AXIS_FRAC_BITS + 2;
  localparam int unsigned TIME_FRAC_BITS = 16;
  localparam int unsigned TIME_ONE       = 1 << TIME_FRAC_BITS;

  // Start-to-end and centre-to-start differences.
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  // One coordinate times one axis component, and the sum of three of them.
  localparam int unsigned PROD_W = DIFF_W + AXIS_BITS;
  localparam int unsigned SUM_W  = PROD_W + 2;
  // Half extent moved to the projection's fraction format.
  localparam int unsigned HALF_W = COORD_BITS + AXIS_FRAC_BITS;
  // Signed slab numerator and denominator.
  localparam int unsigned NUM_W  = ((SUM_W > HALF_W + 1) ? SUM_W : HALF_W + 1) + 1;
  // Divider magnitudes and partial remainder.
  localparam int unsigned REM_W  = NUM_W + 1;
  // Quotient bits and the signed clamped time in [-1, one + 1].
  localparam int unsigned QUO_W  = TIME_FRAC_BITS + 1;
  localparam int unsigned TIME_W = QUO_W + 1;
  // Hit point: movement magnitude times entry time.
  localparam int unsigned HPROD_W = DIFF_W + QUO_W;

  localparam int unsigned PROJ_LAT = 4;
  localparam int unsigned DIV_LAT  = QUO_W + 2;
  localparam int unsigned COMB_LAT = 4;
  localparam int unsigned PIPE_LAT = PROJ_LAT + DIV_LAT + COMB_LAT;

  typedef struct packed {
    logic par;       // movement projection is exactly zero
    logic par_miss;  // parallel and the start lies outside the slab
  } sobb_slab_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] st;
    logic [2:0][DIFF_W-1:0]     mv;
    sobb_slab_t [2:0]           slab;
  } sobb_carry_t;

endpackage

`default_nettype wire

// File: rtl/sobb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobb_if: request and response channels of the slab pipeline
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sobb_req_if import sobb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [3*COORD_BITS-1:0]     segment_start;
  logic [3*COORD_BITS-1:0]     segment_end;
  logic [3*COORD_BITS-1:0]     box_center;
  logic [3*AXIS_BITS-1:0]      box_axis_0;
  logic [3*AXIS_BITS-1:0]      box_axis_1;
  logic [3*AXIS_BITS-1:0]      box_axis_2;
  logic [3*COORD_BITS-1:0]     box_half_extents;

  modport source (output valid, segment_start, segment_end, box_center, box_axis_0,
                  box_axis_1, box_axis_2, box_half_extents, input ready);
  modport sink (input valid, segment_start, segment_end, box_center, box_axis_0,
                box_axis_1, box_axis_2, box_half_extents, output ready);
endinterface

interface sobb_rsp_if import sobb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [TIME_FRAC_BITS:0] entry_time;
  logic [3*COORD_BITS-1:0] hit_point;

  modport source (output valid, hit, entry_time, hit_point, input ready);
  modport sink (input valid, hit, entry_time, hit_point, output ready);
endinterface

`default_nettype wire

// File: rtl/sobb_project.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobb_project: projection front end
// Differences, axis products, projection sums and slab numerators.
// ----------------------------------------------------------------------------
module sobb_project import sobb_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [3*COORD_BITS-1:0]     seg_start_i,
  input  logic [3*COORD_BITS-1:0]     seg_end_i,
  input  logic [3*COORD_BITS-1:0]     center_i,
  input  logic [2:0][3*AXIS_BITS-1:0] axes_i,
  input  logic [3*COORD_BITS-1:0]     half_i,
  output logic signed [NUM_W-1:0]     num_e_o [3],
  output logic signed [NUM_W-1:0]     num_x_o [3],
  output logic signed [NUM_W-1:0]     den_o [3],
  output sobb_carry_t                 carry_o
);

  // Stage 1: differences.
  logic signed [DIFF_W-1:0]    off_q [3];
  logic signed [AXIS_BITS-1:0] ax_q [3][3];
  logic [2:0][COORD_BITS-1:0]  st1_q, half1_q;
  logic [2:0][DIFF_W-1:0]      mv1_q;
  // Stage 2: products.
  logic signed [PROD_W-1:0]    pp_q [3][3];
  logic signed [PROD_W-1:0]    pm_q [3][3];
  logic [2:0][COORD_BITS-1:0]  st2_q, half2_q;
  logic [2:0][DIFF_W-1:0]      mv2_q;
  // Stage 3: sums.
  logic signed [SUM_W-1:0]     p_q [3];
  logic signed [SUM_W-1:0]     m_q [3];
  logic [2:0][HALF_W-1:0]      h_q;
  logic [2:0][COORD_BITS-1:0]  st3_q;
  logic [2:0][DIFF_W-1:0]      mv3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        mv1_q[k] <= DIFF_W'($signed(seg_end_i[k*COORD_BITS +: COORD_BITS]))
                  - DIFF_W'($signed(seg_start_i[k*COORD_BITS +: COORD_BITS]));
        off_q[k] <= DIFF_W'($signed(seg_start_i[k*COORD_BITS +: COORD_BITS]))
                  - DIFF_W'($signed(center_i[k*COORD_BITS +: COORD_BITS]));
        st1_q[k]   <= seg_start_i[k*COORD_BITS +: COORD_BITS];
        half1_q[k] <= half_i[k*COORD_BITS +: COORD_BITS];
        for (int i = 0; i < 3; i++) begin
          ax_q[i][k] <= $signed(axes_i[i][k*AXIS_BITS +: AXIS_BITS]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pp_q[i][k] <= PROD_W'(off_q[k]) * PROD_W'(ax_q[i][k]);
          pm_q[i][k] <= PROD_W'($signed(mv1_q[k])) * PROD_W'(ax_q[i][k]);
        end
      end
      st2_q   <= st1_q;
      mv2_q   <= mv1_q;
      half2_q <= half1_q;
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= SUM_W'(pp_q[i][0]) + SUM_W'(pp_q[i][1]) + SUM_W'(pp_q[i][2]);
        m_q[i] <= SUM_W'(pm_q[i][0]) + SUM_W'(pm_q[i][1]) + SUM_W'(pm_q[i][2]);
        h_q[i] <= {half2_q[i], {AXIS_FRAC_BITS{1'b0}}};
      end
      st3_q <= st2_q;
      mv3_q <= mv2_q;
    end
  end

  // Stage 4: slab numerators and the parallel case.
  logic signed [NUM_W-1:0] h_s [3];
  logic signed [NUM_W-1:0] p_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_s[i] = $signed({{(NUM_W-HALF_W){1'b0}}, h_q[i]});
      p_s[i] = NUM_W'(p_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num_e_o[i] <= -h_s[i] - p_s[i];
        num_x_o[i] <= h_s[i] - p_s[i];
        den_o[i]   <= NUM_W'(m_q[i]);
        carry_o.slab[i].par      <= (m_q[i] == '0);
        carry_o.slab[i].par_miss <= (m_q[i] == '0) && ((p_s[i] < -h_s[i]) || (p_s[i] > h_s[i]));
      end
      carry_o.st <= st3_q;
      carry_o.mv <= mv3_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sobb_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobb_div: pipelined slab time divider
// Restoring division, one quotient bit per stage, clamped signed time out.
// ----------------------------------------------------------------------------
module sobb_div import sobb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic signed [NUM_W-1:0]  den_i,
  output logic signed [TIME_W-1:0] time_o
);

  logic [REM_W-1:0] rem_q [QUO_W+1];
  logic [REM_W-1:0] ad_q  [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic             sat_q [QUO_W+1];

  logic [REM_W-1:0] an_d, ad_d;

  always_comb begin
    an_d = num_i[NUM_W-1] ? REM_W'(-num_i) : REM_W'(num_i);
    ad_d = den_i[NUM_W-1] ? REM_W'(-den_i) : REM_W'(den_i);
    if (num_i[NUM_W-1]) an_d[REM_W-1] = 1'b0;
    if (den_i[NUM_W-1]) ad_d[REM_W-1] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= an_d;
      ad_q[0]  <= ad_d;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[NUM_W-1] ^ den_i[NUM_W-1];
      sat_q[0] <= an_d >= {ad_d[REM_W-2:0], 1'b0};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [REM_W-1:0] rin;
    logic             ge;
    if (k == 0) begin : g_first
      assign rin = rem_q[k];
    end else begin : g_rest
      assign rin = {rem_q[k][REM_W-2:0], 1'b0};
    end
    assign ge = rin >= ad_q[k];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? rin - ad_q[k] : rin;
        ad_q[k+1]  <= ad_q[k];
        quo_q[k+1] <= {quo_q[k][QUO_W-2:0], ge};
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  logic [QUO_W:0]          tq;
  logic signed [TIME_W-1:0] time_d;

  always_comb begin
    tq = sat_q[QUO_W] ? (QUO_W+1)'(2 * TIME_ONE) : {1'b0, quo_q[QUO_W]};
    if (neg_q[QUO_W]) begin
      time_d = (tq != '0) ? -TIME_W'(1) : '0;
    end else if (tq > (QUO_W+1)'(TIME_ONE + 1)) begin
      time_d = TIME_W'(TIME_ONE + 1);
    end else begin
      time_d = $signed(tq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      time_o <= time_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sobb_combine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobb_combine: interval intersection and hit point
// Orders slab times, intersects with [0,1], then forms the contact point.
// ----------------------------------------------------------------------------
module sobb_combine import sobb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [TIME_W-1:0] te_i [3],
  input  logic signed [TIME_W-1:0] tx_i [3],
  input  sobb_carry_t              carry_i,
  output logic                     hit_o,
  output logic [TIME_FRAC_BITS:0]  entry_time_o,
  output logic [3*COORD_BITS-1:0]  hit_point_o
);

  localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(TIME_ONE);

  // Stage 1: per slab interval.
  logic signed [TIME_W-1:0]   lo_q [3];
  logic signed [TIME_W-1:0]   hi_q [3];
  logic                       miss1_q;
  logic [2:0][COORD_BITS-1:0] st1_q, st2_q, st3_q;
  logic [2:0][DIFF_W-1:0]     mv1_q, mv2_q;
  // Stage 2: running interval.
  logic [QUO_W-1:0]           tlo2_q, tlo3_q;
  logic                       miss2_q, miss3_q;
  // Stage 3: products.
  logic [HPROD_W-1:0]         prod_q [3];
  logic [2:0]                 mneg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        if (carry_i.slab[k].par) begin
          lo_q[k] <= '0;
          hi_q[k] <= T_ONE;
        end else begin
          lo_q[k] <= (te_i[k] > tx_i[k]) ? tx_i[k] : te_i[k];
          hi_q[k] <= (te_i[k] > tx_i[k]) ? te_i[k] : tx_i[k];
        end
      end
      miss1_q <= carry_i.slab[0].par_miss | carry_i.slab[1].par_miss
               | carry_i.slab[2].par_miss;
      st1_q <= carry_i.st;
      mv1_q <= carry_i.mv;
    end
  end

  logic signed [TIME_W-1:0] tlo_d, thi_d;

  always_comb begin
    tlo_d = '0;
    thi_d = T_ONE;
    for (int k = 0; k < 3; k++) begin
      if (lo_q[k] > tlo_d) tlo_d = lo_q[k];
      if (hi_q[k] < thi_d) thi_d = hi_q[k];
    end
  end

  logic [DIFF_W-1:0] mmag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mmag[k] = mv2_q[k][DIFF_W-1] ? DIFF_W'(-$signed(mv2_q[k])) : mv2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // The lower bound never drops below zero, so its top bit is free.
      tlo2_q  <= tlo_d[QUO_W-1:0];
      miss2_q <= miss1_q || (tlo_d > thi_d);
      st2_q   <= st1_q;
      mv2_q   <= mv1_q;
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= HPROD_W'(mmag[k]) * HPROD_W'(tlo2_q);
        mneg_q[k] <= mv2_q[k][DIFF_W-1];
      end
      tlo3_q  <= tlo2_q;
      miss3_q <= miss2_q;
      st3_q   <= st2_q;
    end
  end

  logic [COORD_BITS-1:0] step [3];
  logic [COORD_BITS-1:0] pt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      step[k] = COORD_BITS'(prod_q[k] >> TIME_FRAC_BITS);
      pt[k]   = mneg_q[k] ? st3_q[k] - step[k] : st3_q[k] + step[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o        <= !miss3_q;
      entry_time_o <= miss3_q ? '0 : tlo3_q;
      for (int k = 0; k < 3; k++) begin
        hit_point_o[k*COORD_BITS +: COORD_BITS] <= miss3_q ? '0 : pt[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/segment_obb_slab_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_obb_slab_intersect: segment versus oriented box, slab test
// Fully pipelined; one segment/box test may enter in every clock cycle unless stalled.
// ----------------------------------------------------------------------------
// Each request beat carries a segment and an oriented box; each response beat
// gives the hit flag, the entry time in Q1.16 and the first contact point.
// The block takes one beat per cycle while the output is not stalled and
// returns results in order: the projection (differences, axis products, sums,
// slab numerators), then the six parallel dividers, which produce one quotient
// bit per stage, then interval intersection and hit point arithmetic.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and the consumer does not take it, and then the
// request side is held off too, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module segment_obb_slab_intersect import sobb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  sobb_req_if.sink   req_i,
  sobb_rsp_if.source rsp_o
);

  logic [PIPE_LAT-1:0] v_q;
  logic                en;

  // Advance whenever the output register is empty or being emptied.
  assign en          = !v_q[PIPE_LAT-1] || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = v_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAT-2:0], req_i.valid};
    end
  end

  logic signed [NUM_W-1:0]  num_e [3];
  logic signed [NUM_W-1:0]  num_x [3];
  logic signed [NUM_W-1:0]  den [3];
  logic signed [TIME_W-1:0] te [3];
  logic signed [TIME_W-1:0] tx [3];
  sobb_carry_t              carry;
  sobb_carry_t              carry_q [DIV_LAT];

  sobb_project u_project (
    .clk_i       (clk_i),
    .en_i        (en),
    .seg_start_i (req_i.segment_start),
    .seg_end_i   (req_i.segment_end),
    .center_i    (req_i.box_center),
    .axes_i      ({req_i.box_axis_2, req_i.box_axis_1, req_i.box_axis_0}),
    .half_i      (req_i.box_half_extents),
    .num_e_o     (num_e),
    .num_x_o     (num_x),
    .den_o       (den),
    .carry_o     (carry)
  );

  for (genvar i = 0; i < 3; i++) begin : g_slab
    sobb_div u_div_entry (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_e[i]),
      .den_i  (den[i]),
      .time_o (te[i])
    );
    sobb_div u_div_exit (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_x[i]),
      .den_i  (den[i]),
      .time_o (tx[i])
    );
  end

  // Start point, movement and parallel flags wait alongside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      carry_q[0] <= carry;
      for (int s = 1; s < DIV_LAT; s++) begin
        carry_q[s] <= carry_q[s-1];
      end
    end
  end

  sobb_combine u_combine (
    .clk_i        (clk_i),
    .en_i         (en),
    .te_i         (te),
    .tx_i         (tx),
    .carry_i      (carry_q[DIV_LAT-1]),
    .hit_o        (rsp_o.hit),
    .entry_time_o (rsp_o.entry_time),
    .hit_point_o  (rsp_o.hit_point)
  );

  // A miss reports zero time and a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.hit |-> rsp_o.entry_time == '0 && rsp_o.hit_point == '0)
    else $error("miss result carries non-zero time or point");

  // The entry time of a hit never exceeds one.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> rsp_o.entry_time <= (TIME_FRAC_BITS+1)'(TIME_ONE))
    else $error("entry time above one");

  // A held result freezes the pipeline and holds off requests.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while the output is stalled");

  // An accepted request leaves the first valid bit set.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> v_q[0])
    else $error("accepted request lost at pipeline entry");

endmodule

`default_nettype wire
